/* rtl/core/att_pkg.sv */
// shared types and constants of the advertisement tracker table
// no dependencies; imported by every module of the block
package att_pkg;

  // command codes
  localparam logic [1:0] CMD_ADV   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // company ids and subtypes
  localparam logic [15:0] CID_MULTI  = 16'h004C;
  localparam logic [7:0]  SUB_KIND0  = 8'h12;
  localparam logic [7:0]  SUB_KIND1  = 8'h0F;
  localparam logic [15:0] CID_KIND2  = 16'h0075;
  localparam logic [15:0] CID_KIND3  = 16'h0178;
  localparam logic [15:0] CID_KIND4  = 16'h01F7;
  localparam logic [15:0] CID_KIND5  = 16'h0271;

  // tracker kinds
  localparam logic [2:0] KIND_0 = 3'd0;
  localparam logic [2:0] KIND_1 = 3'd1;
  localparam logic [2:0] KIND_2 = 3'd2;
  localparam logic [2:0] KIND_3 = 3'd3;
  localparam logic [2:0] KIND_4 = 3'd4;
  localparam logic [2:0] KIND_5 = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         mfr_length;
    logic [7:0]         mfr_byte0;
    logic [7:0]         mfr_byte1;
    logic [7:0]         mfr_byte2;
    logic [47:0]        device_address;
    logic signed [7:0]  signal_dbm;
    logic [31:0]        now_ms;
    logic [3:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               is_new;
    logic               dropped_full;
    logic               slot_valid;
    logic [3:0]         slot;
    logic [2:0]         kind;
    logic signed [7:0]  stored_dbm;
    logic [31:0]        last_seen_ms;
    logic [47:0]        stored_address;
    logic [3:0]         entry_count;
  } out_item_t;

  // classifier verdict
  typedef struct packed {
    logic       hit;
    logic [2:0] kind;
  } cls_t;

  // one table entry
  typedef struct packed {
    logic [47:0]        address;
    logic [2:0]         kind;
    logic signed [7:0]  dbm;
    logic [31:0]        seen;
  } entry_t;

endpackage

/* rtl/core/att_classify.sv */
// tracker kind classifier from manufacturer data bytes
// depends on att_pkg
module att_classify import att_pkg::*; (
  input  in_item_t item_i,
  output cls_t     cls_o
);

  logic [15:0] cid;

  assign cid = {item_i.mfr_byte1, item_i.mfr_byte0};

  always_comb begin
    cls_o = '0;
    if (item_i.mfr_length >= 8'd2) begin
      if (cid == CID_MULTI) begin
        // subtype byte only counts when present
        if (item_i.mfr_length >= 8'd3) begin
          if (item_i.mfr_byte2 == SUB_KIND0) begin
            cls_o.hit  = 1'b1;
            cls_o.kind = KIND_0;
          end else if (item_i.mfr_byte2 == SUB_KIND1) begin
            cls_o.hit  = 1'b1;
            cls_o.kind = KIND_1;
          end
        end
      end else if (cid == CID_KIND2) begin
        cls_o.hit  = 1'b1;
        cls_o.kind = KIND_2;
      end else if (cid == CID_KIND3) begin
        cls_o.hit  = 1'b1;
        cls_o.kind = KIND_3;
      end else if (cid == CID_KIND4) begin
        cls_o.hit  = 1'b1;
        cls_o.kind = KIND_4;
      end else if (cid == CID_KIND5) begin
        cls_o.hit  = 1'b1;
        cls_o.kind = KIND_5;
      end
    end
  end

endmodule

/* rtl/core/att_entry_ram.sv */
// entry storage: one write port, one read port with registered data
// depends on att_pkg
module att_entry_ram import att_pkg::*; #(
  parameter int unsigned DEPTH  = 12,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output entry_t            rd_data_o
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/att_seq.sv */
// command sequencer with the shared address comparator and entry count
// depends on att_pkg; drives att_entry_ram
module att_seq import att_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 12,
  parameter int unsigned IDX_W         = 4,
  parameter int unsigned CNT_W         = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  input  cls_t             cls_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output out_item_t        res_o,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  entry_t           rd_data_i,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output entry_t           wr_data_o
);

  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_RDWT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  in_item_t         item_q;
  cls_t             cls_q;
  out_item_t        res_q, res_d;
  logic             load_item;

  logic [CMP_W-1:0] r_ext, cnt_cmp;
  logic             issue, addr_hit, full;
  logic [IDX_W+3:0] cmp_slot_w, cnt_slot_w;
  logic [CNT_W+3:0] cnt_now_w, cnt_inc_w;
  logic [CNT_W-1:0] count_inc;

  assign r_ext      = CMP_W'(item_q.read_index);
  assign cnt_cmp    = CMP_W'(count_q);
  assign issue      = rd_idx_q < count_q;
  assign addr_hit   = cmp_vld_q && (rd_data_i.address == item_q.device_address);
  assign full       = count_q == CNT_W'(TABLE_ENTRIES);
  assign count_inc  = count_q + CNT_W'(1);
  assign cmp_slot_w = {4'b0000, cmp_idx_q};
  assign cnt_slot_w = {4'b0000, count_q[IDX_W-1:0]};
  assign cnt_now_w  = {4'b0000, count_q};
  assign cnt_inc_w  = {4'b0000, count_inc};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    res_d     = res_q;
    load_item = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = rd_idx_q[IDX_W-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = cmp_idx_q;
    wr_data_o = {item_q.device_address, cls_q.kind, item_q.signal_dbm, item_q.now_ms};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_item = 1'b1;
          state_d   = ST_DISP;
        end
      end
      ST_DISP: begin
        res_d             = '0;
        res_d.entry_count = cnt_now_w[3:0];
        state_d           = ST_DONE;
        case (item_q.cmd)
          CMD_ADV: begin
            if (cls_q.hit) begin
              rd_idx_d = '0;
              state_d  = ST_SRCH;
            end
          end
          CMD_READ: begin
            res_d.slot = item_q.read_index;
            if (r_ext < cnt_cmp) begin
              rd_en_o   = 1'b1;
              rd_addr_o = r_ext[IDX_W-1:0];
              state_d   = ST_RDWT;
            end
          end
          CMD_CLEAR: begin
            count_d           = '0;
            res_d.entry_count = 4'd0;
          end
          default: begin
          end
        endcase
      end
      ST_SRCH: begin
        if (addr_hit) begin
          // refresh strength and time, keep stored kind
          wr_en_o              = 1'b1;
          wr_addr_o            = cmp_idx_q;
          wr_data_o.kind       = rd_data_i.kind;
          res_d.accepted       = 1'b1;
          res_d.slot_valid     = 1'b1;
          res_d.slot           = cmp_slot_w[3:0];
          res_d.kind           = rd_data_i.kind;
          res_d.stored_dbm     = item_q.signal_dbm;
          res_d.last_seen_ms   = item_q.now_ms;
          res_d.stored_address = item_q.device_address;
          state_d              = ST_DONE;
        end else if (issue) begin
          rd_en_o   = 1'b1;
          rd_idx_d  = rd_idx_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
        end else begin
          // every held entry compared, no match
          if (!full) begin
            wr_en_o              = 1'b1;
            wr_addr_o            = count_q[IDX_W-1:0];
            count_d              = count_inc;
            res_d.accepted       = 1'b1;
            res_d.is_new         = 1'b1;
            res_d.slot_valid     = 1'b1;
            res_d.slot           = cnt_slot_w[3:0];
            res_d.kind           = cls_q.kind;
            res_d.stored_dbm     = item_q.signal_dbm;
            res_d.last_seen_ms   = item_q.now_ms;
            res_d.stored_address = item_q.device_address;
            res_d.entry_count    = cnt_inc_w[3:0];
          end else begin
            res_d.dropped_full = 1'b1;
          end
          state_d = ST_DONE;
        end
      end
      ST_RDWT: begin
        res_d.slot_valid     = 1'b1;
        res_d.kind           = rd_data_i.kind;
        res_d.stored_dbm     = rd_data_i.dbm;
        res_d.last_seen_ms   = rd_data_i.seen;
        res_d.stored_address = rd_data_i.address;
        state_d              = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    if (load_item) begin
      item_q <= in_item_i;
      cls_q  <= cls_i;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;
  assign res_o       = res_q;

endmodule

/* rtl/core/advert_tracker_table.sv */
// advertisement tracker table, top level with the output register
// depends on att_pkg, att_classify, att_entry_ram, att_seq
//
// Keeps a table of up to TABLE_ENTRIES tracker devices keyed by their 48-bit
// address. Every input beat gives exactly one output beat. An advertisement
// beat is classified from its manufacturer bytes into one of six kinds; an
// unclassified one only reports the entry count. A classified one walks the
// held entries through the entry memory, one read per cycle, with a single
// 48-bit comparator checking the previous read. A hit refreshes signal
// strength and time and keeps the stored kind; a miss appends an entry, or
// flags dropped_full when the table is full. A read beat returns one slot,
// a clear beat empties the table by zeroing the count (stored entries stay
// but become unreachable). The block takes one beat at a time. The walk of
// the entry memory sets how long a classified advertisement keeps the block
// busy; a hit ends the walk early. A read of a held slot goes through the
// registered memory read; an unclassified advertisement, a read beyond the
// entry count and every other beat do not. A finished result sits in an
// output register, so a new beat is taken while the previous result still
// waits for out_ready_i; a further finished result waits in the sequencer
// until the register drains.
// There is no clearing pass after reset: the memory is never read beyond
// the entry count.
module advert_tracker_table import att_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // slot index and entry count widths
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  cls_t             cls;
  logic             res_valid, res_take;
  out_item_t        res;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data;

  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q;

  // kind is decided from the incoming beat and captured with it
  att_classify u_classify (
    .item_i (in_item_i),
    .cls_o  (cls)
  );

  att_entry_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  att_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cls_i       (cls),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // output register loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/core/att_checker.sv */
// port-level checks of the advertisement tracker table, bound to the top
// depends on att_pkg and advert_tracker_table
module att_checker import att_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 12
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a waiting input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result beat changed while stalled");

  // one beat in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("beat taken while another is in work");

  // result flags agree with each other
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.is_new || out_item_o.accepted)
                 && (!out_item_o.accepted || out_item_o.slot_valid)
                 && !(out_item_o.dropped_full && out_item_o.accepted))
    else $error("inconsistent result flags");

  // entry count stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (TABLE_ENTRIES > 15) || (out_item_o.entry_count <= TABLE_ENTRIES))
    else $error("entry count beyond table size");

endmodule

bind advert_tracker_table att_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_att_checker (.*);
